### src/pn_pkg.sv
// ----------------------------------------------------------------------------
// pn_pkg - shared types and codes for the path normalizer
// Character type, the special bytes of a path, and the item opcodes.
// ----------------------------------------------------------------------------
`default_nettype none

package pn_pkg;

  typedef logic [7:0] char_t;

  localparam char_t NUL   = 8'h00;
  localparam char_t DOT   = 8'h2E;
  localparam char_t SLASH = 8'h2F;

  // Item opcodes on the input channel.
  localparam logic OP_CHAR   = 1'b0;
  localparam logic OP_COMMIT = 1'b1;

endpackage

`default_nettype wire

### src/pn_in_if.sv
// ----------------------------------------------------------------------------
// pn_in_if - input channel of the path normalizer
// Carries one path byte or one commit request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pn_in_if;
  logic           valid;
  logic           ready;
  logic           op;
  pn_pkg::char_t  ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

`default_nettype wire

### src/pn_out_if.sv
// ----------------------------------------------------------------------------
// pn_out_if - result channel of the path normalizer
// Carries one byte of the normalized path per beat with last and overflow.
// ----------------------------------------------------------------------------
`default_nettype none

interface pn_out_if;
  logic           valid;
  logic           ready;
  pn_pkg::char_t  out_char;
  logic           is_last;
  logic           overflow;

  modport source (output valid, output out_char, output is_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_char, input is_last, input overflow,
                  output ready);
endinterface

`default_nettype wire

### src/pn_ram.sv
// ----------------------------------------------------------------------------
// pn_ram - generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### src/path_normalizer_core.sv
// ----------------------------------------------------------------------------
// path_normalizer_core - streaming Unix path normalizer
// Builds the clean absolute path of a byte stream against a stored working
// directory and emits it on the NUL; a commit beat between paths stores it
// as the new working directory.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents                     | role
//  --------+-----+-----------------------------------+---------------------------
//  in_i    | in  | op, ch                            | path byte or commit request
//  out_o   | out | out_char, is_last, overflow        | one byte of the result path
//
//  A byte inside a component is pushed; the first byte of a component first checks
//  the last result byte and pushes a '/' if needed; the leading '/' of an absolute
//  path sets the result to "/". ".." walks back through the result RAM. The first
//  byte of a relative path first copies the working directory RAM; a commit copies
//  the result RAM into the working directory RAM, an ignored one does nothing. The
//  NUL emits each result byte by a read of the result RAM port, then a load of the
//  output register, after the accept, close, pop and finish steps. Reset clears
//  all control state; the RAMs are not cleared, a flag makes the unwritten working
//  directory read as "/". A stalled result holds in the output register; once the
//  last byte is loaded, the block accepts the next beat behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module path_normalizer_core #(
  parameter int unsigned PATH_MAX = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pn_in_if.sink     in_i,
  pn_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(PATH_MAX);
  localparam int unsigned LW = $clog2(PATH_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE,      // wait for a beat
    S_WD_COPY,   // copy working directory into result RAM
    S_CMT_COPY,  // copy result RAM into working directory RAM
    S_PROC,      // handle the held byte
    S_CB_RD,     // first byte of a component: check the last result byte
    S_CB_CH,     // push the component byte after the separator
    S_POP,       // "..": walk back to the previous slash
    S_FIN,       // empty result becomes "/"
    S_EM_RD,     // issue read of the next result byte
    S_EM_LD      // load it into the output register
  } state_e;

  state_e              state_q, state_d;
  logic [LW-1:0]       len_q, len_d;        // result length
  logic [LW-1:0]       wlen_q, wlen_d;      // working directory length
  logic [LW-1:0]       cstart_q, cstart_d;  // result length before component
  logic [1:0]          clen_q, clen_d;      // component bytes, saturating at 3
  logic                at_start_q, at_start_d;
  logic                ovf_q, ovf_d;
  logic                dots_q, dots_d;      // component is all dots so far
  logic                wd_written_q, wd_written_d;
  pn_pkg::char_t       ch_q, ch_d;
  logic [LW-1:0]       cnt_q, cnt_d;        // copy and emit counter
  logic                rdv_q, rdv_d;        // copy read in flight
  logic                out_valid_q, out_valid_d;
  pn_pkg::char_t       out_char_q, out_char_d;
  logic                out_last_q, out_last_d;
  logic                out_ovf_q, out_ovf_d;

  // RAM ports
  logic                res_we;
  logic [AW-1:0]       res_waddr, res_raddr;
  pn_pkg::char_t       res_wdata, res_rdata;
  logic                wd_we;
  logic [AW-1:0]       wd_waddr, wd_raddr;
  pn_pkg::char_t       wd_wdata, wd_rdata;

  pn_ram #(.WIDTH(8), .DEPTH(PATH_MAX)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (res_raddr),
    .rdata_o (res_rdata)
  );

  pn_ram #(.WIDTH(8), .DEPTH(PATH_MAX)) u_wd_ram (
    .clk_i   (clk_i),
    .we_i    (wd_we),
    .waddr_i (wd_waddr),
    .wdata_i (wd_wdata),
    .raddr_i (wd_raddr),
    .rdata_o (wd_rdata)
  );

  logic [LW-1:0]  len_m1, len_m2, cs_m1, cnt_m1, cnt_p1;
  pn_pkg::char_t  wd_byte;
  logic           push_req;
  pn_pkg::char_t  push_byte;
  logic           char_step;
  state_e         after_comp;

  assign len_m1 = len_q - LW'(1);
  assign len_m2 = len_q - LW'(2);
  assign cs_m1  = cstart_q - LW'(1);
  assign cnt_m1 = cnt_q - LW'(1);
  assign cnt_p1 = cnt_q + LW'(1);

  // Until the first commit the working directory is "/" (length one).
  assign wd_byte    = wd_written_q ? wd_rdata : pn_pkg::SLASH;
  assign after_comp = (ch_q == pn_pkg::NUL) ? S_FIN : S_IDLE;

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    wlen_d       = wlen_q;
    cstart_d     = cstart_q;
    clen_d       = clen_q;
    at_start_d   = at_start_q;
    ovf_d        = ovf_q;
    dots_d       = dots_q;
    wd_written_d = wd_written_q;
    ch_d         = ch_q;
    cnt_d        = cnt_q;
    rdv_d        = rdv_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;
    // Drop the output beat once it is taken.
    out_valid_d  = out_valid_q && !out_o.ready;

    res_we    = 1'b0;
    res_waddr = '0;
    res_wdata = '0;
    res_raddr = '0;
    wd_we     = 1'b0;
    wd_waddr  = '0;
    wd_wdata  = '0;
    wd_raddr  = '0;
    push_req  = 1'b0;
    push_byte = '0;
    char_step = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.op == pn_pkg::OP_COMMIT) begin
            // Commit only between paths and once a path was emitted.
            if (at_start_q && (len_q != '0)) begin
              cnt_d   = '0;
              rdv_d   = 1'b0;
              state_d = S_CMT_COPY;
            end
          end else begin
            ch_d = in_i.ch;
            if (at_start_q) begin
              ovf_d      = 1'b0;
              clen_d     = '0;
              dots_d     = 1'b1;
              at_start_d = 1'b0;
              if (in_i.ch == pn_pkg::SLASH) begin
                // Absolute path: result is "/", the slash itself is a no-op.
                res_we    = 1'b1;
                res_waddr = '0;
                res_wdata = pn_pkg::SLASH;
                len_d     = LW'(1);
              end else begin
                len_d   = '0;
                cnt_d   = '0;
                rdv_d   = 1'b0;
                state_d = S_WD_COPY;
              end
            end else begin
              state_d = S_PROC;
            end
          end
        end
      end

      S_WD_COPY: begin
        if (rdv_q) begin
          push_req  = 1'b1;
          push_byte = wd_byte;
        end
        if (cnt_q < wlen_q) begin
          wd_raddr = cnt_q[AW-1:0];
          cnt_d    = cnt_p1;
          rdv_d    = 1'b1;
        end else begin
          rdv_d = 1'b0;
          if (!rdv_q) begin
            state_d = S_PROC;
          end
        end
      end

      S_CMT_COPY: begin
        if (rdv_q) begin
          wd_we    = 1'b1;
          wd_waddr = cnt_m1[AW-1:0];
          wd_wdata = res_rdata;
        end
        if (cnt_q < len_q) begin
          res_raddr = cnt_q[AW-1:0];
          cnt_d     = cnt_p1;
          rdv_d     = 1'b1;
        end else begin
          rdv_d = 1'b0;
          if (!rdv_q) begin
            wlen_d       = len_q;
            wd_written_d = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end

      S_PROC: begin
        if ((ch_q == pn_pkg::SLASH) || (ch_q == pn_pkg::NUL)) begin
          // Close the component: "." drops it, ".." also pops the parent.
          state_d = after_comp;
          if ((clen_q != 2'd0) && dots_q && ((clen_q == 2'd1) || (clen_q == 2'd2))) begin
            len_d = cstart_q;
            if ((clen_q == 2'd2) && (cstart_q > LW'(1))) begin
              res_raddr = cs_m1[AW-1:0];
              state_d   = S_POP;
            end
          end
          clen_d = '0;
          dots_d = 1'b1;
        end else if (clen_q == 2'd0) begin
          cstart_d = len_q;
          if (len_q == '0) begin
            push_req  = 1'b1;
            push_byte = pn_pkg::SLASH;
            state_d   = S_CB_CH;
          end else begin
            res_raddr = len_m1[AW-1:0];
            state_d   = S_CB_RD;
          end
        end else begin
          char_step = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_CB_RD: begin
        if (res_rdata != pn_pkg::SLASH) begin
          push_req  = 1'b1;
          push_byte = pn_pkg::SLASH;
          state_d   = S_CB_CH;
        end else begin
          char_step = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_CB_CH: begin
        char_step = 1'b1;
        state_d   = S_IDLE;
      end

      S_POP: begin
        len_d = len_m1;
        if ((res_rdata != pn_pkg::SLASH) && (len_q > LW'(2))) begin
          res_raddr = len_m2[AW-1:0];
        end else begin
          state_d = after_comp;
        end
      end

      S_FIN: begin
        if (len_q == '0) begin
          res_we    = 1'b1;
          res_waddr = '0;
          res_wdata = pn_pkg::SLASH;
          len_d     = LW'(1);
        end
        cnt_d   = '0;
        state_d = S_EM_RD;
      end

      S_EM_RD: begin
        // Read only when the output register is free at the next edge.
        if (!out_valid_q || out_o.ready) begin
          res_raddr = cnt_q[AW-1:0];
          state_d   = S_EM_LD;
        end
      end

      S_EM_LD: begin
        out_valid_d = 1'b1;
        out_char_d  = res_rdata;
        out_last_d  = (cnt_p1 == len_q);
        out_ovf_d   = ovf_q;
        cnt_d       = cnt_p1;
        if (cnt_p1 == len_q) begin
          at_start_d = 1'b1;
          ovf_d      = 1'b0;
          clen_d     = '0;
          dots_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_EM_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Append the held byte to the current component.
    if (char_step) begin
      push_req  = 1'b1;
      push_byte = ch_q;
      if (ch_q != pn_pkg::DOT) begin
        dots_d = 1'b0;
      end
      if (clen_q != 2'd3) begin
        clen_d = clen_q + 2'd1;
      end
    end

    // Append one byte to the result; drop it and flag overflow when full.
    if (push_req) begin
      if (len_q < LW'(PATH_MAX)) begin
        res_we    = 1'b1;
        res_waddr = len_q[AW-1:0];
        res_wdata = push_byte;
        len_d     = len_q + LW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      len_q        <= '0;
      wlen_q       <= LW'(1);
      cstart_q     <= '0;
      clen_q       <= '0;
      at_start_q   <= 1'b1;
      ovf_q        <= 1'b0;
      dots_q       <= 1'b1;
      wd_written_q <= 1'b0;
      ch_q         <= '0;
      cnt_q        <= '0;
      rdv_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_char_q   <= '0;
      out_last_q   <= 1'b0;
      out_ovf_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      wlen_q       <= wlen_d;
      cstart_q     <= cstart_d;
      clen_q       <= clen_d;
      at_start_q   <= at_start_d;
      ovf_q        <= ovf_d;
      dots_q       <= dots_d;
      wd_written_q <= wd_written_d;
      ch_q         <= ch_d;
      cnt_q        <= cnt_d;
      rdv_q        <= rdv_d;
      out_valid_q  <= out_valid_d;
      out_char_q   <= out_char_d;
      out_last_q   <= out_last_d;
      out_ovf_q    <= out_ovf_d;
    end
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.is_last  = out_last_q;
  assign out_o.overflow = out_ovf_q;

endmodule

`default_nettype wire

### sim/path_normalizer_core_test.sv
// ----------------------------------------------------------------------------
// path_normalizer_core_test - self-checking bench for the path normalizer
// Streams directed and random paths, built from dot, dot-dot and named
// components with slash runs and commits, into the core. It predicts every
// normalized path byte and checks each result beat in order under four
// idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module path_normalizer_core_test;

  localparam int unsigned PATH_MAX    = 64;
  localparam int          BUF_DEPTH   = 64;
  localparam int          STUCK_LIMIT = 5000;  // cycles with no beat on either side
  localparam int          DRAIN_WAIT  = 300;   // quiet cycles after the last result
  localparam int          PRINT_LIMIT = 40;
  localparam int          PHASE_BEATS = 75;    // minimum random beats queued per phase

  typedef struct packed {
    logic          op;
    pn_pkg::char_t ch;
  } path_beat_t;

  typedef struct packed {
    pn_pkg::char_t ch;
    logic          last;
    logic          ovf;
  } path_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pn_in_if  in_if ();
  pn_out_if out_if ();

  path_normalizer_core #(
    .PATH_MAX(PATH_MAX)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #1 clk_i = ~clk_i;

  path_beat_t pending_beats[$];
  path_byte_t expected_path_bytes[$];

  int mismatch_count = 0;
  int stuck_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Shadow state of the normalizer.
  pn_pkg::char_t res_buf [BUF_DEPTH];
  pn_pkg::char_t wd_buf  [BUF_DEPTH];
  int    res_len;
  int    wd_len;
  int    comp_start;
  int    comp_len;
  bit    at_start;
  bit    ovf_seen;
  bit    all_dots;

  task automatic report(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Path predictor
  // --------------------------------------------------------------------------

  // Append to the result; drop and flag once the buffer is full.
  function automatic void push_char(input pn_pkg::char_t c);
    if (res_len < PATH_MAX && res_len < BUF_DEPTH) begin
      res_buf[res_len] = c;
      res_len++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  // Close the current component: drop "." and pop on "..", never above root.
  function automatic void close_component();
    if (comp_len == 0) return;
    if (all_dots && (comp_len == 1 || comp_len == 2)) begin
      res_len = comp_start;
      if (comp_len == 2 && res_len > 1) begin
        while (res_len > 1 && res_buf[res_len - 1] != pn_pkg::SLASH) res_len--;
        if (res_len > 1) res_len--;
      end
    end
    comp_len = 0;
    all_dots = 1'b1;
  endfunction

  // Advance the shadow state by one accepted input beat; queue any results.
  function automatic void normalize_beat(input logic op, input pn_pkg::char_t ch);
    int k;
    if (op == pn_pkg::OP_COMMIT) begin
      // Commit only between paths and only once a path was emitted.
      if (at_start && res_len > 0) begin
        for (k = 0; k < res_len && k < BUF_DEPTH; k++) wd_buf[k] = res_buf[k];
        wd_len = res_len;
      end
      return;
    end
    if (at_start) begin
      ovf_seen = 1'b0;
      comp_len = 0;
      all_dots = 1'b1;
      if (ch == pn_pkg::SLASH) begin
        res_buf[0] = pn_pkg::SLASH;
        res_len    = 1;
      end else begin
        // Relative path: start from the working directory.
        res_len = 0;
        for (k = 0; k < wd_len && k < BUF_DEPTH; k++) push_char(wd_buf[k]);
      end
      at_start = 1'b0;
    end
    if (ch != pn_pkg::NUL) begin
      if (ch == pn_pkg::SLASH) begin
        close_component();
      end else begin
        if (comp_len == 0) begin
          comp_start = res_len;
          if (res_len == 0 || res_buf[res_len - 1] != pn_pkg::SLASH)
            push_char(pn_pkg::SLASH);
        end
        push_char(ch);
        if (ch != pn_pkg::DOT) all_dots = 1'b0;
        if (comp_len < 127) comp_len++;
      end
      return;
    end
    // NUL: finish the path and emit it.
    close_component();
    if (res_len == 0) begin
      res_buf[0] = pn_pkg::SLASH;
      res_len    = 1;
    end
    for (k = 0; k < res_len && k < BUF_DEPTH; k++)
      expected_path_bytes.push_back('{res_buf[k], (k + 1 == res_len), ovf_seen});
    at_start = 1'b1;
    ovf_seen = 1'b0;
    comp_len = 0;
    all_dots = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------

  function automatic void queue_beat(input logic op, input pn_pkg::char_t ch);
    pending_beats.push_back('{op, ch});
  endfunction

  function automatic void queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_beat(pn_pkg::OP_CHAR, pn_pkg::char_t'(s[i]));
  endfunction

  // Queue one well-formed path with random content, ended by NUL. A long
  // path runs past the buffer to exercise the overflow flag.
  function automatic void queue_random_path(input bit long_path);
    int n_comp, k, j, n_chars, n_slash;
    pn_pkg::char_t c;
    if ($urandom_range(1)) queue_beat(pn_pkg::OP_CHAR, pn_pkg::SLASH);
    n_comp = long_path ? $urandom_range(14, 22) : $urandom_range(0, 5);
    for (k = 0; k < n_comp; k++) begin
      case ($urandom_range(9))
        0, 1: queue_text(".");
        2, 3: queue_text("..");
        4: begin
          if ($urandom_range(1)) queue_text("...");
          else queue_text(".x");
        end
        default: begin
          n_chars = long_path ? $urandom_range(3, 8) : $urandom_range(1, 4);
          for (j = 0; j < n_chars; j++) begin
            if ($urandom_range(3) == 0) c = pn_pkg::char_t'($urandom_range(1, 255));
            else c = pn_pkg::char_t'("a" + $urandom_range(25));
            queue_beat(pn_pkg::OP_CHAR, c);
          end
        end
      endcase
      // Drop a commit into the middle of the path now and then; it is ignored.
      if ($urandom_range(19) == 0)
        queue_beat(pn_pkg::OP_COMMIT, pn_pkg::char_t'($urandom_range(255)));
      if (k + 1 < n_comp || $urandom_range(1)) begin
        n_slash = $urandom_range(1, 3);
        for (j = 0; j < n_slash; j++) queue_beat(pn_pkg::OP_CHAR, pn_pkg::SLASH);
      end
    end
    queue_beat(pn_pkg::OP_CHAR, pn_pkg::NUL);
    if ($urandom_range(3) == 0)
      queue_beat(pn_pkg::OP_COMMIT, pn_pkg::char_t'($urandom_range(255)));
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: advance to the next pending beat whenever the slot is free
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.op    <= pn_pkg::OP_CHAR;
      in_if.ch    <= pn_pkg::NUL;
    end else if (!in_if.valid || in_if.ready) begin
      // The beat on the wires was taken at this edge: predict its results.
      if (in_if.valid) normalize_beat(in_if.op, in_if.ch);
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.op    <= pending_beats[0].op;
        in_if.ch    <= pending_beats[0].ch;
        void'(pending_beats.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted beat against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    path_byte_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_path_bytes.size() == 0) begin
          report($sformatf("unexpected result char=%02h last=%b ovf=%b",
                           out_if.out_char, out_if.is_last, out_if.overflow));
        end else begin
          want = expected_path_bytes.pop_front();
          if (out_if.out_char !== want.ch)
            report($sformatf("out_char %02h, want %02h", out_if.out_char, want.ch));
          if (out_if.is_last !== want.last)
            report($sformatf("is_last %b, want %b (char %02h)",
                             out_if.is_last, want.last, want.ch));
          if (out_if.overflow !== want.ovf)
            report($sformatf("overflow %b, want %b (char %02h)",
                             out_if.overflow, want.ovf, want.ch));
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count cycles in which neither side moves a beat.
  always @(posedge clk_i) begin
    if (rst_ni && !(in_if.valid && in_if.ready) && !(out_if.valid && out_if.ready))
      stuck_cycles <= stuck_cycles + 1;
    else
      stuck_cycles <= 0;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    int phase, target;

    rst_ni = 1'b0;

    // Shadow state after reset: working directory is root.
    res_len    = 0;
    wd_buf[0]  = pn_pkg::SLASH;
    wd_len     = 1;
    comp_start = 0;
    comp_len   = 0;
    at_start   = 1'b1;
    ovf_seen   = 1'b0;
    all_dots   = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: commit before any path was emitted, then an empty path.
    queue_beat(pn_pkg::OP_COMMIT, 8'hFF);
    queue_beat(pn_pkg::OP_CHAR, pn_pkg::NUL);
    // Slash run, an all-ones byte, "." and ".." popping it.
    queue_text("//a");
    queue_beat(pn_pkg::OP_CHAR, 8'hFF);
    queue_text("/./../b");
    queue_beat(pn_pkg::OP_CHAR, pn_pkg::NUL);
    queue_beat(pn_pkg::OP_COMMIT, pn_pkg::NUL);
    // Relative path with a commit in mid path and a name ending in a dot.
    queue_text("c");
    queue_beat(pn_pkg::OP_COMMIT, 8'h5A);
    queue_text(".");
    queue_beat(pn_pkg::OP_CHAR, pn_pkg::NUL);
    // Empty path yields the working directory; ".." never climbs above root.
    queue_beat(pn_pkg::OP_CHAR, pn_pkg::NUL);
    queue_text("../..");
    queue_beat(pn_pkg::OP_CHAR, pn_pkg::NUL);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      target = pending_beats.size() + PHASE_BEATS;
      while (pending_beats.size() < target) queue_random_path($urandom_range(15) == 0);
      // Hold until every beat is in and every result is out.
      while (pending_beats.size() != 0 || in_if.valid || expected_path_bytes.size() != 0)
        @(posedge clk_i);
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && expected_path_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
